### sv/atbfc_pkg.sv
// Shared types, codes and helpers for the audio triple buffer fill control block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package atbfc_pkg;

   localparam int unsigned LEN_W        = 18;
   localparam int unsigned ADDR_W       = 24;
   localparam int unsigned OFS_OUT_W    = 15;
   localparam int unsigned BYTES_OUT_W  = 14;
   localparam int unsigned REQ_TDATA_W  = 48;
   localparam int unsigned RSP_TDATA_W  = 80;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned RESULT_DEPTH = 4;

   // Input word kinds carried on the request tuser.
   localparam logic [1:0] MODE_LENGTH = 2'd0;
   localparam logic [1:0] MODE_UPDATE = 2'd1;
   localparam logic [1:0] MODE_STOP   = 2'd2;

   // Result word kinds carried on the response tuser.
   localparam logic [1:0] ACT_COPY    = 2'd0;
   localparam logic [1:0] ACT_SILENCE = 2'd1;
   localparam logic [1:0] ACT_STATUS  = 2'd2;

   // Finished-section code meaning that no section ended.
   localparam logic [1:0] SEC_NONE = 2'd3;

   localparam logic [LEN_W-1:0]  LEN_MASK  = 18'h3FFF8;
   localparam logic [ADDR_W-1:0] ADDR_MASK = 24'hFFFFF8;

   // Word index of the alternate-microcode register on the register port.
   localparam logic CSR_IDX_ALT_UCODE = 1'b0;

   typedef enum logic [1:0] {
      SEC_EMPTY,
      SEC_PLAYING,
      SEC_HALF,
      SEC_FULL
   } sec_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LW_SETUP,
      S_LW_HALF,
      S_LW_FULL,
      S_FILL,
      S_UT_SILENCE,
      S_UT_PLAY,
      S_STOP,
      S_FINISH,
      S_SEND
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]             action;
      logic [OFS_OUT_W-1:0]   dest_offset;
      logic [ADDR_W-1:0]      source_address;
      logic [BYTES_OUT_W-1:0] byte_count;
      logic                   raise_interrupt;
      logic                   fifo_full;
      logic [LEN_W-1:0]       remaining_length;
   } rsp_entry_type;

   typedef struct packed {
      logic           emit;
      rsp_entry_type  entry;
      sec_status_type status;
      logic [LEN_W-1:0]  pending;
      logic [ADDR_W-1:0] read_ptr;
      logic           fifo_full;
   } fill_result_type;

   typedef struct packed {
      logic wr_en;
      logic send;
   } buf_ctrl_type;

   typedef struct packed {
      logic empty;
      logic drained;
   } buf_status_type;

   // Sum of two section numbers, each below three, modulo three.
   function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= 3'd3) begin
         sum = sum - 3'd3;
      end
      return sum[1:0];
   endfunction

endpackage

`default_nettype wire

### sv/atbfc_fill_unit.sv
// Shared fill unit: works out one section fill (copy size, offset, new counts).
// Depends on atbfc_pkg.
`default_nettype none

module atbfc_fill_unit #(
   parameter int unsigned SECTION_BYTES = 8192,
   parameter int unsigned SB_W          = 14,
   parameter int unsigned OFS_W         = 15
) (
   input  wire logic [1:0]                  sec,
   input  var  atbfc_pkg::sec_status_type   status,
   input  wire logic [atbfc_pkg::LEN_W-1:0] pending,
   input  wire logic [SB_W-1:0]             space,
   input  wire logic [atbfc_pkg::ADDR_W-1:0] read_ptr,
   input  wire logic                        fifo_full,
   input  wire logic                        alt_mode,
   output atbfc_pkg::fill_result_type       result,
   output logic [SB_W-1:0]                  space_out
);

   localparam logic [atbfc_pkg::LEN_W-1:0] SB_LEN   = atbfc_pkg::LEN_W'(SECTION_BYTES);
   localparam logic [SB_W-1:0]             SB_SPACE = SB_W'(SECTION_BYTES);
   localparam logic [OFS_W-1:0]            SB_OFS   = OFS_W'(SECTION_BYTES);

   logic [OFS_W-1:0]                sec_base;
   logic [OFS_W-1:0]                sec_end;
   logic [OFS_W-1:0]                dest;
   logic [SB_W-1:0]                 n;
   logic                            copied;
   logic                            irq;
   logic [atbfc_pkg::LEN_W-1:0]     space_len;

   assign sec_base  = OFS_W'(sec) * SB_OFS;
   assign sec_end   = sec_base + SB_OFS;
   assign space_len = atbfc_pkg::LEN_W'(space);

   always_comb begin
      result           = '0;
      result.status    = status;
      result.pending   = pending;
      result.read_ptr  = read_ptr;
      result.fifo_full = fifo_full;
      result.entry.action = atbfc_pkg::ACT_STATUS;
      space_out        = space;
      n                = '0;
      dest             = '0;
      copied           = 1'b0;
      irq              = 1'b0;

      if (!alt_mode && (pending == '0)) begin
         // Nothing left to copy: report and drop the fifo-full flag.
         result.fifo_full                  = 1'b0;
         result.emit                       = 1'b1;
         result.entry.raise_interrupt      = 1'b1;
         result.entry.fifo_full            = 1'b0;
         result.entry.remaining_length     = pending;
      end else begin
         case (status)
            atbfc_pkg::SEC_EMPTY: begin
               dest   = sec_base;
               copied = 1'b1;
               if (pending >= SB_LEN) begin
                  n              = SB_SPACE;
                  result.status  = atbfc_pkg::SEC_FULL;
                  result.pending = pending - SB_LEN;
               end else begin
                  n              = SB_W'(pending);
                  result.status  = atbfc_pkg::SEC_HALF;
                  space_out      = SB_SPACE - SB_W'(pending);
                  result.pending = '0;
               end
            end
            atbfc_pkg::SEC_HALF: begin
               dest   = sec_end - OFS_W'(space);
               copied = 1'b1;
               if (pending >= space_len) begin
                  n              = space;
                  result.status  = atbfc_pkg::SEC_FULL;
                  result.pending = pending - space_len;
               end else begin
                  n              = SB_W'(pending);
                  space_out      = space - SB_W'(pending);
                  result.pending = '0;
               end
            end
            default: begin
            end
         endcase

         if (copied) begin
            result.read_ptr = read_ptr + atbfc_pkg::ADDR_W'(n);
         end
         if (!alt_mode && (result.pending == '0)) begin
            result.fifo_full = 1'b0;
            irq              = 1'b1;
         end
         if (copied || irq) begin
            result.emit                   = 1'b1;
            result.entry.action           = copied ? atbfc_pkg::ACT_COPY
                                                   : atbfc_pkg::ACT_STATUS;
            result.entry.dest_offset      = atbfc_pkg::OFS_OUT_W'(dest);
            result.entry.source_address   = copied ? read_ptr : '0;
            result.entry.byte_count       = atbfc_pkg::BYTES_OUT_W'(n);
            result.entry.raise_interrupt  = irq;
            result.entry.fifo_full        = result.fifo_full;
            result.entry.remaining_length = result.pending;
         end
      end
   end

endmodule

`default_nettype wire

### sv/atbfc_result_buffer.sv
// Result buffer: holds the words of one input and plays them out on the response stream.
// Depends on atbfc_pkg.
`default_nettype none

module atbfc_result_buffer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  var  atbfc_pkg::buf_ctrl_type             ctrl,
   input  var  atbfc_pkg::rsp_entry_type            wr_entry,
   input  wire logic                                play_active,
   output atbfc_pkg::buf_status_type                status,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [atbfc_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [1:0]                               rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int unsigned IDX_W = $clog2(atbfc_pkg::RESULT_DEPTH);
   localparam int unsigned CNT_W = $clog2(atbfc_pkg::RESULT_DEPTH + 1);

   atbfc_pkg::rsp_entry_type entries_ff [atbfc_pkg::RESULT_DEPTH];
   atbfc_pkg::rsp_entry_type rd_entry;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic             sending_ff, sending_in;
   logic             is_last;
   logic             take;
   logic             wr_ok;

   assign rd_entry = entries_ff[rd_ff];
   assign is_last  = ((CNT_W'(rd_ff) + CNT_W'(1)) == cnt_ff);
   assign take     = sending_ff & rsp_tready;
   assign wr_ok    = ctrl.wr_en & ~sending_ff;

   always_comb begin
      cnt_in     = cnt_ff;
      rd_in      = rd_ff;
      sending_in = sending_ff;
      if (wr_ok) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (ctrl.send) begin
         sending_in = 1'b1;
      end
      if (take) begin
         if (is_last) begin
            sending_in = 1'b0;
            cnt_in     = '0;
            rd_in      = '0;
         end else begin
            rd_in = rd_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rd_ff      <= '0;
         sending_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         rd_ff      <= rd_in;
         sending_ff <= sending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         entries_ff[cnt_ff[IDX_W-1:0]] <= wr_entry;
      end
   end

   assign status.empty   = (cnt_ff == '0);
   assign status.drained = take & is_last;

   assign rsp_tvalid = sending_ff;
   assign rsp_tlast  = is_last;
   assign rsp_tuser  = rd_entry.action;
   assign rsp_tdata  = {6'b0, play_active, rd_entry.remaining_length, rd_entry.fifo_full,
                        rd_entry.raise_interrupt, rd_entry.byte_count,
                        rd_entry.source_address, rd_entry.dest_offset};

endmodule

`default_nettype wire

### sv/audio_triple_buffer_fill_control_unit.sv
// Top level of the audio triple buffer fill control block: sequencer, state and register port.
// Depends on atbfc_pkg, atbfc_fill_unit and atbfc_result_buffer.
//
// Usage. The block keeps the status of a three-section playback ring and turns each
// request word into one to four result words. A request word carries its kind on
// req_tuser (length write, update tick or stop); a length write loads the pending
// byte count and source address and issues fill copies, an update tick silences the
// finished section and refills, a stop empties the ring. Each result word says
// whether to copy samples, silence a section or only report status; rsp_tlast marks
// the final word of a request.
// Timing. One request is worked on at a time and req_tready is low meanwhile. Fills
// go one per cycle through a single shared fill unit, and the result words of a
// request are only offered once its work is done. The words then leave at one
// per cycle while rsp_tready is high, and req_tready rises the cycle after the last
// word is taken. A stalled receiver simply holds the current word; nothing is lost.
// Reset empties every section, clears the counts, the play flag, the fifo-full flag
// and the register, with no clearing pass. The register is to be written through the
// csr_ port only while the block is idle; the block itself does not enforce this.
`default_nettype none

module audio_triple_buffer_fill_control_unit #(
   parameter int unsigned SECTION_BYTES = 8192
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: length_word [17:0], dram_address [41:18], finished_section [43:42], zeros.
   input  wire logic [atbfc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: mode [1:0].
   input  wire logic [1:0]                          req_tuser,
   // Response stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: dest_offset [14:0], source_address [38:15], byte_count [52:39],
   // raise_interrupt [53], fifo_full [54], remaining_length [72:55],
   // play_active [73], zeros.
   output logic [atbfc_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // tuser: action [1:0].
   output logic [1:0]                               rsp_tuser,
   output logic                                     rsp_tlast,
   // Register port.
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [atbfc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [atbfc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [atbfc_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                     csr_pready
);

   // Free space in a section may equal a whole section; ring offsets reach three sections.
   localparam int unsigned SB_W  = $clog2(SECTION_BYTES + 1);
   localparam int unsigned OFS_W = $clog2(3 * SECTION_BYTES + 1);

   localparam int unsigned LEN_W  = atbfc_pkg::LEN_W;
   localparam int unsigned ADDR_W = atbfc_pkg::ADDR_W;

   atbfc_pkg::fsm_state_type  state_ff, state_in;

   // Ring state, as seen by the software driving the block.
   atbfc_pkg::sec_status_type status_ff [3];
   atbfc_pkg::sec_status_type status_in [3];
   logic [LEN_W-1:0]          pending_ff, pending_in;
   logic [ADDR_W-1:0]         rp_ff, rp_in;
   logic [SB_W-1:0]           space_ff, space_in;
   logic                      playback_ff, playback_in;
   logic                      fifo_ff, fifo_in;
   logic                      alt_ff, alt_in;

   // Fields of the request under work, and the queue of sections to fill.
   logic                      is_update_ff, is_update_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [1:0]                fin_ff, fin_in;
   logic [1:0]                start_ff, start_in;
   logic [1:0]                tgt_ff [3];
   logic [1:0]                tgt_in [3];
   logic [1:0]                tgt_cnt_ff, tgt_cnt_in;
   logic [1:0]                tgt_idx_ff, tgt_idx_in;

   // Section searches over the three status entries.
   logic [1:0]                start_calc;
   logic                      half_found;
   logic [1:0]                half_sec;
   logic [1:0]                half_cand;
   logic                      full_found;
   logic [1:0]                full_sec;
   logic [1:0]                full_cand;
   logic                      any_full;

   // Shared fill unit.
   logic [1:0]                   fill_sec;
   atbfc_pkg::fill_result_type   fill_res;
   logic [SB_W-1:0]              fill_space;
   logic                         fill_apply;

   // Result buffer.
   atbfc_pkg::buf_ctrl_type      buf_ctrl;
   atbfc_pkg::buf_status_type    buf_status;
   atbfc_pkg::rsp_entry_type     wr_entry;

   logic                         req_take;
   logic                         csr_wr;
   logic [OFS_W-1:0]             silence_dest;

   assign req_tready   = (state_ff == atbfc_pkg::S_IDLE);
   assign req_take     = req_tvalid & req_tready;
   assign csr_pready   = 1'b1;
   assign csr_wr       = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata   = (csr_paddr[2] == atbfc_pkg::CSR_IDX_ALT_UCODE)
                         ? {{(atbfc_pkg::CSR_DATA_W - 1){1'b0}}, alt_ff} : '0;
   assign silence_dest = OFS_W'(fin_ff) * OFS_W'(SECTION_BYTES);

   // A length write starts after the playing section; the last playing one found wins.
   always_comb begin
      start_calc = 2'd0;
      if (playback_ff) begin
         for (int i = 0; i < 3; i++) begin
            if (status_ff[i] == atbfc_pkg::SEC_PLAYING) begin
               start_calc = atbfc_pkg::add_mod3(2'(i), 2'd1);
            end
         end
      end
   end

   // First half-full and first full section, walking round from the start section.
   always_comb begin
      half_found = 1'b0;
      half_sec   = start_ff;
      half_cand  = start_ff;
      full_found = 1'b0;
      full_sec   = start_ff;
      full_cand  = start_ff;
      for (int i = 0; i < 3; i++) begin
         half_cand = atbfc_pkg::add_mod3(start_ff, 2'(i));
         if (!half_found && (status_ff[half_cand] == atbfc_pkg::SEC_HALF)) begin
            half_found = 1'b1;
            half_sec   = half_cand;
         end
         full_cand = atbfc_pkg::add_mod3(start_ff, 2'(i));
         if (!full_found && (status_ff[full_cand] == atbfc_pkg::SEC_FULL)) begin
            full_found = 1'b1;
            full_sec   = full_cand;
         end
      end
   end

   assign any_full = (status_ff[0] == atbfc_pkg::SEC_FULL) ||
                     (status_ff[1] == atbfc_pkg::SEC_FULL) ||
                     (status_ff[2] == atbfc_pkg::SEC_FULL);

   assign fill_sec   = (state_ff == atbfc_pkg::S_LW_HALF) ? half_sec : tgt_ff[tgt_idx_ff];
   assign fill_apply = ((state_ff == atbfc_pkg::S_LW_HALF) && half_found) ||
                       (state_ff == atbfc_pkg::S_FILL);

   atbfc_fill_unit #(
      .SECTION_BYTES (SECTION_BYTES),
      .SB_W          (SB_W),
      .OFS_W         (OFS_W)
   ) u_fill_unit (
      .sec       (fill_sec),
      .status    (status_ff[fill_sec]),
      .pending   (pending_ff),
      .space     (space_ff),
      .read_ptr  (rp_ff),
      .fifo_full (fifo_ff),
      .alt_mode  (alt_ff),
      .result    (fill_res),
      .space_out (fill_space)
   );

   atbfc_result_buffer u_result_buffer (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (buf_ctrl),
      .wr_entry    (wr_entry),
      .play_active (playback_ff),
      .status      (buf_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         atbfc_pkg::S_IDLE: begin
            if (req_take) begin
               case (req_tuser)
                  atbfc_pkg::MODE_LENGTH: state_in = atbfc_pkg::S_LW_SETUP;
                  atbfc_pkg::MODE_UPDATE: state_in = atbfc_pkg::S_UT_SILENCE;
                  atbfc_pkg::MODE_STOP:   state_in = atbfc_pkg::S_STOP;
                  default:                state_in = atbfc_pkg::S_FINISH;
               endcase
            end
         end
         atbfc_pkg::S_LW_SETUP: state_in = atbfc_pkg::S_LW_HALF;
         atbfc_pkg::S_LW_HALF:  state_in = atbfc_pkg::S_LW_FULL;
         atbfc_pkg::S_LW_FULL:  state_in = atbfc_pkg::S_FILL;
         atbfc_pkg::S_FILL: begin
            if (tgt_idx_ff == (tgt_cnt_ff - 2'd1)) begin
               state_in = is_update_ff ? atbfc_pkg::S_UT_PLAY : atbfc_pkg::S_FINISH;
            end
         end
         atbfc_pkg::S_UT_SILENCE: begin
            state_in = (fin_ff != atbfc_pkg::SEC_NONE) ? atbfc_pkg::S_FILL
                                                       : atbfc_pkg::S_UT_PLAY;
         end
         atbfc_pkg::S_UT_PLAY: state_in = atbfc_pkg::S_FINISH;
         atbfc_pkg::S_STOP:    state_in = atbfc_pkg::S_FINISH;
         atbfc_pkg::S_FINISH:  state_in = atbfc_pkg::S_SEND;
         atbfc_pkg::S_SEND: begin
            if (buf_status.drained) begin
               state_in = atbfc_pkg::S_IDLE;
            end
         end
         default: state_in = atbfc_pkg::S_IDLE;
      endcase
   end

   // Datapath updates and result words for each sequencer step.
   always_comb begin
      status_in    = status_ff;
      pending_in   = pending_ff;
      rp_in        = rp_ff;
      space_in     = space_ff;
      playback_in  = playback_ff;
      fifo_in      = fifo_ff;
      alt_in       = alt_ff;
      is_update_in = is_update_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      fin_in       = fin_ff;
      start_in     = start_ff;
      tgt_in       = tgt_ff;
      tgt_cnt_in   = tgt_cnt_ff;
      tgt_idx_in   = tgt_idx_ff;
      buf_ctrl     = '0;
      wr_entry     = '0;
      wr_entry.action           = atbfc_pkg::ACT_STATUS;
      wr_entry.fifo_full        = fifo_ff;
      wr_entry.remaining_length = pending_ff;

      if (csr_wr && (csr_paddr[2] == atbfc_pkg::CSR_IDX_ALT_UCODE)) begin
         alt_in = csr_pwdata[0];
      end

      case (state_ff)
         atbfc_pkg::S_IDLE: begin
            if (req_take) begin
               is_update_in = (req_tuser == atbfc_pkg::MODE_UPDATE);
               len_in       = req_tdata[LEN_W-1:0];
               addr_in      = req_tdata[LEN_W +: ADDR_W];
               fin_in       = req_tdata[LEN_W + ADDR_W +: 2];
            end
         end
         atbfc_pkg::S_LW_SETUP: begin
            if (!alt_ff) begin
               fifo_in = 1'b1;
            end
            pending_in = len_ff & atbfc_pkg::LEN_MASK;
            rp_in      = addr_ff & atbfc_pkg::ADDR_MASK;
            start_in   = start_calc;
         end
         atbfc_pkg::S_LW_FULL: begin
            tgt_idx_in = 2'd0;
            if (full_found) begin
               // Fill the two sections that follow the full one.
               tgt_in[0]  = atbfc_pkg::add_mod3(full_sec, 2'd1);
               tgt_in[1]  = atbfc_pkg::add_mod3(full_sec, 2'd2);
               tgt_cnt_in = 2'd2;
            end else begin
               tgt_in[0]  = start_ff;
               tgt_in[1]  = atbfc_pkg::add_mod3(start_ff, 2'd1);
               tgt_in[2]  = atbfc_pkg::add_mod3(start_ff, 2'd2);
               tgt_cnt_in = 2'd3;
            end
         end
         atbfc_pkg::S_FILL: begin
            tgt_idx_in = tgt_idx_ff + 2'd1;
         end
         atbfc_pkg::S_UT_SILENCE: begin
            tgt_idx_in = 2'd0;
            if (fin_ff != atbfc_pkg::SEC_NONE) begin
               // Silence the finished section, move playback on, then refill.
               status_in[fin_ff]                          = atbfc_pkg::SEC_EMPTY;
               status_in[atbfc_pkg::add_mod3(fin_ff, 2'd1)] = atbfc_pkg::SEC_PLAYING;
               buf_ctrl.wr_en          = 1'b1;
               wr_entry.action         = atbfc_pkg::ACT_SILENCE;
               wr_entry.dest_offset    = atbfc_pkg::OFS_OUT_W'(silence_dest);
               wr_entry.byte_count     = atbfc_pkg::BYTES_OUT_W'(SECTION_BYTES);
               tgt_in[0]  = atbfc_pkg::add_mod3(fin_ff, 2'd2);
               tgt_in[1]  = fin_ff;
               tgt_cnt_in = 2'd2;
            end
         end
         atbfc_pkg::S_UT_PLAY: begin
            if (!playback_ff && any_full) begin
               playback_in = 1'b1;
            end
         end
         atbfc_pkg::S_STOP: begin
            for (int i = 0; i < 3; i++) begin
               status_in[i] = atbfc_pkg::SEC_EMPTY;
            end
            playback_in              = 1'b0;
            fifo_in                  = 1'b0;
            buf_ctrl.wr_en           = 1'b1;
            wr_entry.raise_interrupt = 1'b1;
            wr_entry.fifo_full       = 1'b0;
         end
         atbfc_pkg::S_FINISH: begin
            // A request that produced nothing still answers with one status word.
            buf_ctrl.send  = 1'b1;
            buf_ctrl.wr_en = buf_status.empty;
         end
         default: begin
         end
      endcase

      if (fill_apply) begin
         status_in[fill_sec] = fill_res.status;
         pending_in          = fill_res.pending;
         rp_in               = fill_res.read_ptr;
         fifo_in             = fill_res.fifo_full;
         space_in            = fill_space;
         buf_ctrl.wr_en      = fill_res.emit;
         wr_entry            = fill_res.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= atbfc_pkg::S_IDLE;
         for (int i = 0; i < 3; i++) begin
            status_ff[i] <= atbfc_pkg::SEC_EMPTY;
         end
         pending_ff  <= '0;
         rp_ff       <= '0;
         space_ff    <= '0;
         playback_ff <= 1'b0;
         fifo_ff     <= 1'b0;
         alt_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         status_ff   <= status_in;
         pending_ff  <= pending_in;
         rp_ff       <= rp_in;
         space_ff    <= space_in;
         playback_ff <= playback_in;
         fifo_ff     <= fifo_in;
         alt_ff      <= alt_in;
      end
   end

   always_ff @(posedge clock) begin
      is_update_ff <= is_update_in;
      len_ff       <= len_in;
      addr_ff      <= addr_in;
      fin_ff       <= fin_in;
      start_ff     <= start_in;
      tgt_ff       <= tgt_in;
      tgt_cnt_ff   <= tgt_cnt_in;
      tgt_idx_ff   <= tgt_idx_in;
   end

endmodule

`default_nettype wire

### sv/atbfc_checker.sv
// Port checker for the audio triple buffer fill control block, bound to its top level.
// Depends on the top level's ports and atbfc_pkg widths.
`default_nettype none

module atbfc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [atbfc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic                                rsp_tlast
);

   // Requests are only taken once every word of the previous one has gone.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request ready while a result word is offered");

   // A result word is never offered straight after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result word offered straight after a request was taken");

   // After the final word the block is idle again; before it, more words follow.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after the final result word");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("result run ended without a final word");

   // A stalled word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

endmodule

bind audio_triple_buffer_fill_control_unit atbfc_checker u_atbfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
